### rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry concurrent checks.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rrs_pkg.sv
// Package for the round-robin scheduler step unit: widths, codes and payload types.
// Depends on nothing; imported by the top level.
package rrs_pkg;

	localparam int MAX_PROCS_DEFAULT = 16;
	localparam int DATA_W            = 16;
	localparam int TIME_W            = 24;
	localparam int PID_W             = 5;

	localparam logic [DATA_W-1:0] QUANTUM_RESET = DATA_W'(4);

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_LOAD  = 2'd1;
	localparam logic [1:0] ACT_STEP  = 2'd2;

	localparam logic [1:0] ST_ACCEPTED = 2'd0;
	localparam logic [1:0] ST_SEGMENT  = 2'd1;
	localparam logic [1:0] ST_ALL_DONE = 2'd2;
	localparam logic [1:0] ST_REFUSED  = 2'd3;

	typedef struct packed {
		logic [1:0]        action;
		logic [DATA_W-1:0] arrival_time;
		logic [DATA_W-1:0] burst_time;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [PID_W-1:0]  process_id;
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] end_time;
		logic              finished;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
	} rsp_t;

	typedef struct packed {
		logic [DATA_W-1:0] arrival;
		logic [DATA_W-1:0] burst;
		logic [DATA_W-1:0] remaining;
	} entry_t;

endpackage

### rtl/rrs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module rrs_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### rtl/round_robin_scheduler_step_unit.sv
// Top level of the round-robin scheduler step unit: sequencer, shared adder and result register.
// Depends on rrs_pkg, rrs_ram and assert_macros.svh.
//
// Clear, load and refused commands stay in idle: the result strobes on done in the cycle
// after the transfer and busy stays low. A step visits the process table one entry at a time
// through the single read port of the table RAM: S_SCAN and S_CHECK per entry, S_SCAN again at
// each wrap past the last loaded entry. The segment found runs S_SLICE, S_ADVANCE, then S_TURN
// and S_WAIT if the process completes, then S_REPORT, on the shared 24-bit adder; done strobes
// in the cycle after S_REPORT. A step with every process finished answers from idle. Results
// are shown for one cycle only and cannot be held off, so the receiver must take every strobe.
`include "assert_macros.svh"

module round_robin_scheduler_step_unit #(
	parameter int MAX_PROCS = rrs_pkg::MAX_PROCS_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  rrs_pkg::cmd_t             cmd,
	output logic                      done,
	output rrs_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [rrs_pkg::DATA_W-1:0] cfg_wdata
);

	import rrs_pkg::*;

	localparam int CW = $clog2(MAX_PROCS + 1);
	localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PROCS);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_SCAN    = 8'b0000_0010,
		S_CHECK   = 8'b0000_0100,
		S_SLICE   = 8'b0000_1000,
		S_ADVANCE = 8'b0001_0000,
		S_TURN    = 8'b0010_0000,
		S_WAIT    = 8'b0100_0000,
		S_REPORT  = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       completed_q;
	logic [CW-1:0]       scan_q;
	logic [TIME_W-1:0]   time_q;
	logic                round_ran_q;
	logic                started_q;
	logic [DATA_W-1:0]   quantum_q;
	logic                done_q;

	logic [DATA_W-1:0]   slice_q;
	logic                fin_q;
	logic [TIME_W-1:0]   start_q;
	logic [TIME_W-1:0]   ta_q;
	logic [TIME_W-1:0]   wt_q;
	rsp_t                rsp_q;

	logic [TIME_W-1:0]   alu_a;
	logic [TIME_W-1:0]   alu_b;
	logic                alu_sub;
	logic [TIME_W:0]     alu_sum;
	logic                alu_carry;
	logic [TIME_W-1:0]   alu_res;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	entry_t              ram_wdata;
	logic                ram_re;
	entry_t              ram_rdata;

	logic                load_ok;
	logic                all_done;
	logic                eligible;
	logic                longer;
	logic [CW-1:0]       scan_next;
	logic                fire;
	rsp_t                rsp_d;

	rrs_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_PROCS)
	) u_table (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(scan_q[AW-1:0]),
		.rd_data(ram_rdata)
	);

	assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
		+ (TIME_W+1)'(alu_sub);
	assign alu_carry = alu_sum[TIME_W];
	assign alu_res   = alu_sum[TIME_W-1:0];

	assign load_ok   = (count_q < MAX_CNT) && (cmd.burst_time != '0) && !started_q;
	assign all_done  = (completed_q >= count_q);
	assign eligible  = (ram_rdata.remaining != '0) && alu_carry;
	assign longer    = alu_carry && (alu_res != '0);
	assign scan_next = scan_q + CW'(1);

	always_comb begin
		alu_a     = time_q;
		alu_b     = '0;
		alu_sub   = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = '{arrival: cmd.arrival_time, burst: cmd.burst_time,
			remaining: cmd.burst_time};
		ram_re    = 1'b0;
		fire      = 1'b0;
		rsp_d     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (cmd.action)
						ACT_CLEAR: begin
							fire         = 1'b1;
							rsp_d.status = ST_ACCEPTED;
						end
						ACT_LOAD: begin
							fire = 1'b1;
							if (load_ok) begin
								ram_we           = 1'b1;
								rsp_d.status     = ST_ACCEPTED;
								rsp_d.process_id = PID_W'(count_q + CW'(1));
							end else begin
								rsp_d.status = ST_REFUSED;
							end
						end
						ACT_STEP: begin
							if (all_done) begin
								fire           = 1'b1;
								rsp_d.status   = ST_ALL_DONE;
								rsp_d.end_time = time_q;
							end
						end
						default: begin
							fire         = 1'b1;
							rsp_d.status = ST_REFUSED;
						end
					endcase
				end
			end
			S_SCAN: begin
				ram_re = (scan_q < count_q);
				alu_b  = TIME_W'(1);
			end
			S_CHECK: begin
				alu_b   = TIME_W'(ram_rdata.arrival);
				alu_sub = 1'b1;
			end
			S_SLICE: begin
				alu_a     = TIME_W'(ram_rdata.remaining);
				alu_b     = TIME_W'(quantum_q);
				alu_sub   = 1'b1;
				ram_we    = 1'b1;
				ram_waddr = scan_q[AW-1:0];
				ram_wdata = '{arrival: ram_rdata.arrival, burst: ram_rdata.burst,
					remaining: (longer ? alu_res[DATA_W-1:0] : '0)};
			end
			S_ADVANCE: begin
				alu_b = TIME_W'(slice_q);
			end
			S_TURN: begin
				alu_b   = TIME_W'(ram_rdata.arrival);
				alu_sub = 1'b1;
			end
			S_WAIT: begin
				alu_a   = ta_q;
				alu_b   = TIME_W'(ram_rdata.burst);
				alu_sub = 1'b1;
			end
			S_REPORT: begin
				fire             = 1'b1;
				rsp_d.status     = ST_SEGMENT;
				rsp_d.process_id = PID_W'(scan_next);
				rsp_d.start_time = start_q;
				rsp_d.end_time   = time_q;
				rsp_d.finished   = fin_q;
				rsp_d.turnaround = fin_q ? ta_q : '0;
				rsp_d.waiting    = fin_q ? wt_q : '0;
			end
			default: begin
				fire = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			completed_q <= '0;
			scan_q      <= '0;
			time_q      <= '0;
			round_ran_q <= 1'b0;
			started_q   <= 1'b0;
			quantum_q   <= QUANTUM_RESET;
			done_q      <= 1'b0;
		end else begin
			done_q <= fire;
			if (cfg_we) begin
				quantum_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						unique case (cmd.action)
							ACT_CLEAR: begin
								count_q     <= '0;
								completed_q <= '0;
								scan_q      <= '0;
								time_q      <= '0;
								round_ran_q <= 1'b0;
								started_q   <= 1'b0;
							end
							ACT_LOAD: begin
								if (load_ok) begin
									count_q <= count_q + CW'(1);
								end
							end
							ACT_STEP: begin
								started_q <= 1'b1;
								if (!all_done) begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_q >= count_q) begin
						if (!round_ran_q) begin
							time_q <= alu_res;
						end
						round_ran_q <= 1'b0;
						scan_q      <= '0;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (eligible) begin
						state_q <= S_SLICE;
					end else begin
						scan_q  <= scan_next;
						state_q <= S_SCAN;
					end
				end
				S_SLICE: begin
					state_q <= S_ADVANCE;
				end
				S_ADVANCE: begin
					time_q <= alu_res;
					if (fin_q) begin
						completed_q <= completed_q + CW'(1);
						state_q     <= S_TURN;
					end else begin
						state_q <= S_REPORT;
					end
				end
				S_TURN: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					state_q <= S_REPORT;
				end
				S_REPORT: begin
					if (scan_next >= count_q) begin
						scan_q      <= '0;
						round_ran_q <= 1'b0;
					end else begin
						scan_q      <= scan_next;
						round_ran_q <= 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SLICE) begin
			slice_q <= longer ? quantum_q : ram_rdata.remaining;
			fin_q   <= !longer;
			start_q <= time_q;
		end
		if (state_q == S_TURN) begin
			ta_q <= alu_res;
		end
		if (state_q == S_WAIT) begin
			wt_q <= alu_res;
		end
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	`ASSERT_ALWAYS(a_done_when_idle, !(done && busy), "result strobed while a step is in progress")
	`ASSERT_ALWAYS(a_completed_bound, completed_q <= count_q, "more completions than processes")
	`ASSERT_ALWAYS(a_scan_bound, scan_q <= count_q, "scan position beyond the loaded table")
	`ASSERT_NEXT(a_step_progress, start && !busy && cmd.action == ACT_STEP, busy || done, "step transfer neither started a scan nor answered")

endmodule
